/* sv/pvbp_pkg.sv */
// Package for the prefix varint bit packer.
// Holds the code constants, the configuration register map and the encoder result type.
// No dependencies.
package pvbp_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned AccW      = 48;
  localparam int unsigned ByteCntW  = 3;
  localparam int unsigned PendW     = 7;
  localparam int unsigned PendCntW  = 3;
  localparam int unsigned LenW      = 6;
  localparam int unsigned LimitW    = 7;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [LimitW-1:0] LimitReset = 7'd100;
  localparam logic [LimitW-1:0] LimitCap   = 7'd126;
  localparam logic [LimitW-1:0] LimitTop   = 7'd127;

  localparam logic [7:0] PrefixThree = 8'h7f;
  localparam logic [7:0] PrefixFour  = 8'hff;

  localparam logic [LenW-1:0] LenOne   = 6'd7;
  localparam logic [LenW-1:0] LenTwo   = 6'd14;
  localparam logic [LenW-1:0] LenThree = 6'd32;
  localparam logic [LenW-1:0] LenFour  = 6'd40;

  // Register index is taken from the word address bit.
  localparam logic RegIdxLimit = 1'b0;

  typedef struct packed {
    logic [AccW-1:0]     acc;
    logic [ByteCntW-1:0] nbytes;
    logic                last;
    logic [PendW-1:0]    pend_bits;
    logic [PendCntW-1:0] pend_cnt;
  } enc_res_t;

endpackage

/* sv/pvbp_encode.sv */
// Combinational encoder of the prefix varint bit packer.
// Builds the prefix code of one value, merges it with the pending bits and counts bytes.
// Depends on pvbp_pkg.
module pvbp_encode (
  input  logic [pvbp_pkg::ValueW-1:0]   value_i,
  input  logic                          last_i,
  input  logic [pvbp_pkg::LimitW-1:0]   limit_i,
  input  logic [pvbp_pkg::PendW-1:0]    pend_bits_i,
  input  logic [pvbp_pkg::PendCntW-1:0] pend_cnt_i,
  output pvbp_pkg::enc_res_t            res_o
);
  import pvbp_pkg::*;

  logic [LimitW-1:0]   lim;
  logic                is_one;
  logic                is_two;
  logic [ValueW:0]     off;
  logic [ValueW-7:0]   hi;
  logic [LimitW-1:0]   room;
  logic [LimitW-1:0]   two_low;
  logic [39:0]         code;
  logic [LenW-1:0]     len;
  logic [AccW-1:0]     acc;
  logic [LenW-1:0]     total;
  logic [ByteCntW-1:0] nfull;
  logic                extra;
  logic [AccW-1:0]     rest;

  always_comb begin
    lim     = (limit_i == LimitTop) ? LimitCap : limit_i;
    is_one  = value_i < {{(ValueW-LimitW){1'b0}}, lim};
    off     = {1'b0, value_i} - {{(ValueW+1-LimitW){1'b0}}, lim} + 33'd1;
    hi      = off[ValueW:7];
    room    = LimitTop - lim;
    is_two  = (hi[ValueW-7:7] == '0) && (hi[6:0] < room);
    two_low = lim + hi[6:0];

    if (is_one) begin
      code = {{(40-LimitW){1'b0}}, value_i[6:0]};
      len  = LenOne;
    end else if (is_two) begin
      code = {26'd0, off[6:0], two_low};
      len  = LenTwo;
    end else if (value_i[31:24] == 8'd0) begin
      code = {8'd0, value_i[23:0], PrefixThree};
      len  = LenThree;
    end else begin
      code = {value_i, PrefixFour};
      len  = LenFour;
    end

    acc   = ({8'd0, code} << pend_cnt_i) | {{(AccW-PendW){1'b0}}, pend_bits_i};
    total = len + {{(LenW-PendCntW){1'b0}}, pend_cnt_i};
    nfull = total[5:3];
    extra = last_i && (total[2:0] != 3'd0);
    rest  = acc >> {nfull, 3'b000};

    res_o.acc    = acc;
    res_o.nbytes = nfull + {{(ByteCntW-1){1'b0}}, extra};
    res_o.last   = last_i;
    if (last_i) begin
      res_o.pend_bits = '0;
      res_o.pend_cnt  = '0;
    end else begin
      res_o.pend_bits = rest[PendW-1:0];
      res_o.pend_cnt  = total[2:0];
    end
  end

endmodule

/* sv/prefix_varint_bit_packer.sv */
// Prefix varint bit packer, top level.
// Streams 32-bit values in, packed code bytes out; holds the APB register and the datapath.
// Depends on pvbp_pkg and pvbp_encode.
//
// Each value is coded in 7, 14, 32 or 40 bits and appended LSB-first to a running bit
// stream; every full byte leaves on the output stream, and a value sent with tlast also
// flushes the partial byte with zero padding and marks its final byte with tlast. The block
// sends one byte per cycle while m_axis_tready takes them; a value yields zero to six bytes.
// A value passes an input register, is encoded into a byte shift register, and each byte
// goes through an output register. The one_byte_limit register is at byte address 0 and
// must be written only while the block is idle.
module prefix_varint_bit_packer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // [31:0] value
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [7:0] code_byte
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pvbp_pkg::ApbAddrW-1:0]   paddr,
  input  logic [pvbp_pkg::ApbDataW-1:0]   pwdata,
  output logic [pvbp_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import pvbp_pkg::*;

  logic [LimitW-1:0]   limit_q;
  logic                in_valid_q;
  logic [ValueW-1:0]   in_value_q;
  logic                in_last_q;
  logic [PendW-1:0]    pend_bits_q;
  logic [PendCntW-1:0] pend_cnt_q;
  logic [AccW-1:0]     work_data_q;
  logic [ByteCntW-1:0] work_cnt_q;
  logic                work_last_q;
  logic                out_valid_q;
  logic [7:0]          out_data_q;
  logic                out_last_q;
  logic                s_accept;
  logic                out_load;
  logic                work_free;
  logic                in_move;
  logic                cfg_write;
  enc_res_t            enc;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == RegIdxLimit);
  assign prdata    = (paddr[2] == RegIdxLimit) ? {{(ApbDataW-LimitW){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_write) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  assign out_load      = (work_cnt_q != '0) && (!out_valid_q || m_axis_tready);
  assign work_free     = (work_cnt_q == '0) || ((work_cnt_q == ByteCntW'(1)) && out_load);
  assign in_move       = in_valid_q && work_free;
  assign s_axis_tready = !in_valid_q || in_move;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (in_move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_value_q <= s_axis_tdata;
      in_last_q  <= s_axis_tlast;
    end
  end

  pvbp_encode u_encode (
    .value_i     (in_value_q),
    .last_i      (in_last_q),
    .limit_i     (limit_q),
    .pend_bits_i (pend_bits_q),
    .pend_cnt_i  (pend_cnt_q),
    .res_o       (enc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      work_cnt_q  <= '0;
    end else if (in_move) begin
      pend_bits_q <= enc.pend_bits;
      pend_cnt_q  <= enc.pend_cnt;
      work_cnt_q  <= enc.nbytes;
    end else if (out_load) begin
      work_cnt_q  <= work_cnt_q - ByteCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      work_data_q <= enc.acc;
      work_last_q <= enc.last;
    end else if (out_load) begin
      work_data_q <= work_data_q >> 8;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= work_data_q[7:0];
      out_last_q <= work_last_q && (work_cnt_q == ByteCntW'(1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_work_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_cnt_q <= ByteCntW'(6))
    else $error("Byte count of the work register exceeds six.");

  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_cnt_q == '0) |-> (pend_bits_q == '0))
    else $error("Pending bits are set while the pending count is zero.");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_move) |=> in_valid_q)
    else $error("An input transaction was dropped before encoding.");

endmodule
